// ----- hw/rtl/relo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// relo_pkg: shared definitions for the ring entry offset locator
// Sizes, pointer types and small helpers used by the locator and its RAM.
// ----------------------------------------------------------------------------
package relo_pkg;

    // Number of entries held in the ring.
    localparam int Depth = 10;

    // Field widths of one stored entry.
    localparam int AddrW = 32;
    localparam int SizeW = 16;
    localparam int OffsW = 20;
    localparam int SlotW = AddrW + SizeW;

    // Pointer, entry count and running sum widths.
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam int SumW = $clog2(Depth) + 21;

    // Stream payload widths, padded to whole bytes.
    localparam int InDataW  = 72;
    localparam int OutDataW = 64;

    // Request kinds carried on the input tuser bit.
    localparam logic ReqAdd  = 1'b0;
    localparam logic ReqFind = 1'b1;

    typedef logic [PtrW-1:0] ptr_t;
    typedef logic [CntW-1:0] cnt_t;
    typedef logic [SumW-1:0] sum_t;

    // Advance a ring pointer, wrapping at the last entry.
    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(Depth - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ring_entry_offset_locator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_entry_offset_locator_unit: overwriting ring of buffers with offset lookup
// Keeps a ring of (address, size) entries and maps a character offset in the
// concatenation of the stored entries to the entry and the byte within it.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An add beat writes the entry at the
// write pointer (overwriting the oldest entry when the ring is full) and yields
// a zero result. A find beat walks the stored entries oldest first, one entry
// per cycle through the registered read port of the entry RAM, visiting at most
// Depth entries. The next request is accepted as soon as the result has been
// moved to the output register; a result left waiting on m_tready does not hold
// off the next request, but it does hold off the result of that request. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ring_entry_offset_locator_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: entry_addr [31:0], entry_size [47:32], search_pos [67:48], zero pad
    input  wire logic [relo_pkg::InDataW-1:0]      s_tdata,
    // s_tuser: req_type [0]
    input  wire logic                              s_tuser,
    // Result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: found_addr [31:0], found_size [47:32], byte_offset [63:48]
    output logic      [relo_pkg::OutDataW-1:0]     m_tdata,
    // m_tuser: hit [0]
    output logic                                   m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    relo_pkg::ptr_t wp_reg, wp_next;
    relo_pkg::ptr_t rp_reg, rp_next;
    logic           full_reg, full_next;

    relo_pkg::ptr_t idx_reg, idx_next;
    relo_pkg::cnt_t k_reg, k_next;
    relo_pkg::cnt_t count_reg, count_next;
    relo_pkg::sum_t base_reg, base_next;
    logic [relo_pkg::OffsW-1:0] target_reg, target_next;

    logic                         res_hit_reg, res_hit_next;
    logic [relo_pkg::AddrW-1:0]   res_addr_reg, res_addr_next;
    logic [relo_pkg::SizeW-1:0]   res_size_reg, res_size_next;
    logic [relo_pkg::SizeW-1:0]   res_offs_reg, res_offs_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [relo_pkg::OutDataW-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    // Request fields.
    logic [relo_pkg::AddrW-1:0] in_addr;
    logic [relo_pkg::SizeW-1:0] in_size;
    logic [relo_pkg::OffsW-1:0] in_offs;
    logic                       in_accept;

    assign in_addr   = s_tdata[relo_pkg::AddrW-1:0];
    assign in_size   = s_tdata[relo_pkg::AddrW +: relo_pkg::SizeW];
    assign in_offs   = s_tdata[relo_pkg::SlotW +: relo_pkg::OffsW];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Entry RAM: size in the upper bits, address in the lower bits.
    logic                        ram_we;
    relo_pkg::ptr_t              ram_raddr;
    logic [relo_pkg::SlotW-1:0]  ram_wdata;
    logic [relo_pkg::SlotW-1:0]  ram_rdata;

    assign ram_we    = in_accept && (s_tuser == relo_pkg::ReqAdd);
    assign ram_wdata = {in_size, in_addr};
    // The oldest entry is read while idle; during the walk the next entry is read.
    assign ram_raddr = (state_reg == S_WALK) ? relo_pkg::ring_next(idx_reg) : rp_reg;

    relo_ram #(
        .Width (relo_pkg::SlotW),
        .Depth (relo_pkg::Depth)
    ) u_slots (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Number of stored entries.
    logic [relo_pkg::PtrW:0] span;
    relo_pkg::cnt_t          stored;

    always_comb begin
        if (wp_reg >= rp_reg) begin
            span = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            span = {1'b0, wp_reg} + (relo_pkg::PtrW + 1)'(relo_pkg::Depth)
                   - {1'b0, rp_reg};
        end
        stored = full_reg ? relo_pkg::cnt_t'(relo_pkg::Depth)
                          : relo_pkg::cnt_t'(span);
    end

    // Walk step: does the entry just read hold the target?
    logic [relo_pkg::SizeW-1:0] cur_size;
    logic [relo_pkg::AddrW-1:0] cur_addr;
    relo_pkg::sum_t             target_ext;
    relo_pkg::sum_t             end_sum;
    relo_pkg::sum_t             rel_offs;
    logic                       cur_hit;

    assign cur_addr   = ram_rdata[relo_pkg::AddrW-1:0];
    assign cur_size   = ram_rdata[relo_pkg::AddrW +: relo_pkg::SizeW];
    assign target_ext = relo_pkg::sum_t'(target_reg);
    assign end_sum    = base_reg + relo_pkg::sum_t'(cur_size);
    assign cur_hit    = (target_ext < end_sum);
    assign rel_offs   = target_ext - base_reg;

    // Sequencer and ring pointer update.
    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        full_next     = full_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        target_next   = target_reg;
        res_hit_next  = res_hit_reg;
        res_addr_next = res_addr_reg;
        res_size_next = res_size_reg;
        res_offs_next = res_offs_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    res_hit_next  = 1'b0;
                    res_addr_next = '0;
                    res_size_next = '0;
                    res_offs_next = '0;
                    if (s_tuser == relo_pkg::ReqAdd) begin
                        wp_next = relo_pkg::ring_next(wp_reg);
                        if (full_reg) begin
                            rp_next = relo_pkg::ring_next(rp_reg);
                        end
                        if (relo_pkg::ring_next(wp_reg) ==
                            (full_reg ? relo_pkg::ring_next(rp_reg) : rp_reg)) begin
                            full_next = 1'b1;
                        end
                        state_next = S_SEND;
                    end else begin
                        target_next = in_offs;
                        count_next  = stored;
                        idx_next    = rp_reg;
                        k_next      = '0;
                        base_next   = '0;
                        state_next  = (stored == '0) ? S_SEND : S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (cur_hit) begin
                    res_hit_next  = 1'b1;
                    res_addr_next = cur_addr;
                    res_size_next = cur_size;
                    res_offs_next = rel_offs[relo_pkg::SizeW-1:0];
                    state_next    = S_SEND;
                end else if (k_reg == count_reg - relo_pkg::cnt_t'(1)) begin
                    state_next = S_SEND;
                end else begin
                    base_next = end_sum;
                    k_next    = k_reg + relo_pkg::cnt_t'(1);
                    idx_next  = relo_pkg::ring_next(idx_reg);
                end
            end
            S_SEND: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_hit_reg;
                    m_tdata_next  = {res_offs_reg, res_size_reg, res_addr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            full_reg     <= full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Walk and result payload registers.
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        count_reg    <= count_next;
        base_reg     <= base_next;
        target_reg   <= target_next;
        res_hit_reg  <= res_hit_next;
        res_addr_reg <= res_addr_next;
        res_size_reg <= res_size_next;
        res_offs_reg <= res_offs_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A full ring has its pointers together.
    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (wp_reg == rp_reg))
        else $error("ring full with pointers apart");

    // Pointers stay within the ring.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg < relo_pkg::ptr_t'(relo_pkg::Depth - 1)
         || wp_reg == relo_pkg::ptr_t'(relo_pkg::Depth - 1))
        && (rp_reg < relo_pkg::ptr_t'(relo_pkg::Depth - 1)
         || rp_reg == relo_pkg::ptr_t'(relo_pkg::Depth - 1)))
        else $error("ring pointer out of range");

    // The walk never visits more entries than are stored.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (k_reg < count_reg))
        else $error("walk passed the stored entries");

    // A new result is loaded only from the send state.
    a_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_SEND))
        else $error("result loaded outside the send state");

    // A result without hit carries zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("miss result with non-zero fields");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/relo_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// relo_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module relo_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
    input  wire logic [Width-1:0]                       wdata,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
    output logic      [Width-1:0]                       rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ring entry offset locator
// Drives add and find requests over the request stream and checks every
// result beat against a behavioural ring kept inside the bench. The ring is
// walked oldest first to locate a character offset, as the block does.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int Depth      = relo_pkg::Depth;
    localparam int IdleLimit  = 1000;
    localparam int TailCycles = 20;
    localparam int HoldCycles = 250;
    localparam int PrintCap   = 40;

    // One request as queued for the driver.
    typedef struct {
        logic        kind;
        logic [31:0] addr;
        logic [15:0] size;
        logic [19:0] offset;
        bit          drain;
    } request_t;

    // One result beat as the block should present it.
    typedef struct packed {
        logic        hit;
        logic [31:0] addr;
        logic [15:0] size;
        logic [15:0] boff;
    } locate_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [relo_pkg::InDataW-1:0]  s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [relo_pkg::OutDataW-1:0] m_tdata;
    logic                          m_tuser;

    request_t       pending_requests[$];
    locate_result_t expected_results[$];
    int unsigned    gen_sizes[$];

    // Behavioural copy of the ring.
    logic [31:0] slot_addr[Depth];
    logic [15:0] slot_size[Depth];
    int unsigned wr_ptr       = 0;
    int unsigned rd_ptr       = 0;
    bit          ring_is_full = 1'b0;

    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    int unsigned requests_out = 0;
    int unsigned idle_cycles  = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned holds_done   = 0;
    bit          beat_taken   = 1'b0;
    bit          stim_loaded  = 1'b0;

    ring_entry_offset_locator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and a single reset at the start.
    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int unsigned wrap_inc(input int unsigned p);
        return (p + 1) % Depth;
    endfunction

    // Apply one request to the ring and return the result it should give.
    function automatic locate_result_t serve_request(input logic kind,
                                                     input logic [31:0] addr,
                                                     input logic [15:0] size,
                                                     input logic [19:0] offset);
        locate_result_t r;
        int unsigned    count;
        int unsigned    base;
        int unsigned    idx;
        r = '0;
        if (kind == relo_pkg::ReqAdd) begin
            slot_addr[wr_ptr] = addr;
            slot_size[wr_ptr] = size;
            if (ring_is_full) begin
                rd_ptr = wrap_inc(rd_ptr);
            end
            wr_ptr = wrap_inc(wr_ptr);
            if (wr_ptr == rd_ptr) begin
                ring_is_full = 1'b1;
            end
        end else begin
            count = ring_is_full ? Depth : (wr_ptr + Depth - rd_ptr) % Depth;
            base  = 0;
            idx   = rd_ptr;
            // Only stored entries are visited; zero-size ones hold no character.
            for (int k = 0; k < count; k++) begin
                if (!r.hit && offset < base + slot_size[idx]) begin
                    r.hit  = 1'b1;
                    r.addr = slot_addr[idx];
                    r.size = slot_size[idx];
                    r.boff = 16'(offset - base);
                end
                base += slot_size[idx];
                idx = wrap_inc(idx);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PrintCap) begin
            $display("MISMATCH result %0d %s: got %h, want %h", results_seen, what, got,
                     want);
        end
    endtask

    // Mostly short gaps, a few long ones, none at all in quiet stretches.
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Queue a request and track the sizes the ring will hold at that point.
    task automatic queue_request(input logic kind, input logic [31:0] addr,
                                 input logic [15:0] size, input logic [19:0] offset,
                                 input bit drain);
        request_t q;
        q.kind   = kind;
        q.addr   = addr;
        q.size   = size;
        q.offset = offset;
        q.drain  = drain;
        pending_requests.push_back(q);
        if (kind == relo_pkg::ReqAdd) begin
            gen_sizes.push_back(size);
            if (gen_sizes.size() > Depth) begin
                void'(gen_sizes.pop_front());
            end
        end
    endtask

    function automatic int unsigned stored_chars();
        int unsigned total;
        total = 0;
        foreach (gen_sizes[i]) begin
            total += gen_sizes[i];
        end
        return total;
    endfunction

    // Stimulus: directed corners first, then random traffic.
    initial begin
        int unsigned total;
        int unsigned pick;
        logic [15:0] sz;
        logic [19:0] off;

        // Finds on an empty ring.
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'h0, 1'b0);
        queue_request(relo_pkg::ReqFind, '1, '1, 20'hFFFFF, 1'b0);
        // A zero-size entry holds nothing.
        queue_request(relo_pkg::ReqAdd, 32'h0, 16'h0, 20'hFFFFF, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'h0, 1'b0);
        // Largest entry, first and last character, then just past the end.
        queue_request(relo_pkg::ReqAdd, 32'hFFFF_FFFF, 16'hFFFF, 20'h0, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'h0, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'd65534, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'd65535, 1'b0);
        queue_request(relo_pkg::ReqAdd, 32'h1234_5678, 16'd1, 20'h0, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'd65535, 1'b0);
        // Fill the ring and wrap it so the oldest entries are overwritten.
        for (int k = 0; k < 9; k++) begin
            queue_request(relo_pkg::ReqAdd, 32'hA5A5_0000 + k, 16'(k + 2), 20'h0, 1'b0);
        end
        total = stored_chars();
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'h0, 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'(total - 1), 1'b0);
        queue_request(relo_pkg::ReqFind, 32'h0, 16'h0, 20'hFFFFF, 1'b0);

        // Random traffic; every so often the sender waits for the block to drain.
        for (int n = 0; n < 1000; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    sz = 16'h0;
                end else if (pick < 45) begin
                    sz = 16'($urandom_range(1, 16));
                end else if (pick < 85) begin
                    sz = 16'($urandom_range(1, 4000));
                end else begin
                    sz = 16'($urandom);
                end
                queue_request(relo_pkg::ReqAdd, $urandom, sz, 20'($urandom), n % 250 == 249);
            end else begin
                total = stored_chars();
                pick  = $urandom_range(0, 99);
                if (pick < 70 && total > 0) begin
                    off = 20'($urandom_range(0, total - 1));
                end else if (pick < 85) begin
                    off = 20'(total + $urandom_range(0, 2));
                end else begin
                    off = 20'($urandom);
                end
                queue_request(relo_pkg::ReqFind, $urandom, 16'($urandom), off,
                              n % 250 == 249);
            end
        end
        stim_loaded = 1'b1;

        // Wait for the last beat to be taken and every result to arrive.
        do begin
            @(posedge aclk);
        end while (!(pending_requests.size() == 0 && !s_tvalid &&
                     expected_results.size() == 0));
        repeat (TailCycles) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Request driver: presents queued beats at the falling edge.
    always @(negedge aclk) begin
        logic     nxt_valid;
        request_t q;
        nxt_valid = s_tvalid;
        if (beat_taken) begin
            beat_taken = 1'b0;
            nxt_valid  = 1'b0;
        end
        if (aresetn && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_results.size() != 0)) begin
                q = pending_requests.pop_front();
                s_tuser   <= q.kind;
                s_tdata   <= {4'h0, q.offset, q.size, q.addr};
                nxt_valid = 1'b1;
                requests_out++;
                send_gap = pick_gap((requests_out / 100) % 3 == 1);
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Result receiver: random stalls, quiet stretches and two long hold-offs.
    always @(negedge aclk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!aresetn) begin
            nxt_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if ((holds_done == 0 && results_seen >= 60) ||
                     (holds_done == 1 && results_seen >= 700)) begin
            holds_done++;
            hold_left = HoldCycles;
            nxt_ready = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_ready = 1'b0;
        end else if (m_tready) begin
            recv_gap = pick_gap((results_seen / 128) % 3 == 2);
            nxt_ready = (recv_gap == 0);
        end
        m_tready <= nxt_ready;
    end

    // Predict on accepted requests, then check accepted results in order.
    always @(posedge aclk) begin
        locate_result_t want;
        bit             moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(serve_request(s_tuser, s_tdata[31:0],
                                                     s_tdata[47:32], s_tdata[67:48]));
            beat_taken = 1'b1;
            moved = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.hit) begin
                    report_mismatch("hit", 32'(m_tuser), 32'(want.hit));
                end
                if (m_tdata[31:0] !== want.addr) begin
                    report_mismatch("found_addr", m_tdata[31:0], want.addr);
                end
                if (m_tdata[47:32] !== want.size) begin
                    report_mismatch("found_size", 32'(m_tdata[47:32]), 32'(want.size));
                end
                if (m_tdata[63:48] !== want.boff) begin
                    report_mismatch("byte_offset", 32'(m_tdata[63:48]), 32'(want.boff));
                end
            end
            results_seen++;
        end
        // Watchdog on cycles with no beat moving on either side.
        if (!aresetn || moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
hw/rtl/relo_pkg.sv
hw/rtl/relo_ram.sv
hw/rtl/ring_entry_offset_locator_unit.sv
tb/sv/tb_top.sv
